// ----- hdl/wcfb_pkg.sv -----
// Shared types, word table and constants for the word clock frame builder.
package wcfb_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
    } time_req_t;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [10:0] row_leds;
        logic        last_row;
        logic        bad_time;
    } row_result_t;

    // Classified frame: which words are lit, handed from front to back
    typedef struct packed {
        logic       bad;
        logic       it_is;
        logic       oclock;
        logic       five;
        logic       ten;
        logic       quarter;
        logic       twenty;
        logic       half;
        logic       past;
        logic       to;
        logic [3:0] hour_sel;
        logic [2:0] fine;
    } frame_desc_t;

    // Position of one word on the letter grid
    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic [3:0] len;
    } word_pos_t;

    localparam int unsigned GRID_COLS = 11;
    localparam logic [3:0]  LAST_ROW  = 4'd10;
    localparam logic [5:0]  PAST_LIMIT = 6'd34;
    localparam logic [5:0]  MIN_STEP   = 6'd5;
    localparam logic [4:0]  HOURS_ON_DIAL = 5'd12;
    localparam logic [4:0]  MAX_HOUR   = 5'd23;
    localparam logic [5:0]  MAX_MINUTE = 6'd59;

    // Configuration register indexes
    localparam logic [0:0] CFG_SHOW_IT_IS   = 1'b0;
    localparam logic [0:0] CFG_SNAKE_WIRING = 1'b1;

    localparam word_pos_t POS_IT      = '{row: 4'd0, col: 4'd0, len: 4'd2};
    localparam word_pos_t POS_IS      = '{row: 4'd0, col: 4'd3, len: 4'd2};
    localparam word_pos_t POS_FIVE    = '{row: 4'd2, col: 4'd7, len: 4'd4};
    localparam word_pos_t POS_TEN     = '{row: 4'd3, col: 4'd0, len: 4'd3};
    localparam word_pos_t POS_QTR     = '{row: 4'd1, col: 4'd3, len: 4'd7};
    localparam word_pos_t POS_TWENTY  = '{row: 4'd2, col: 4'd0, len: 4'd6};
    localparam word_pos_t POS_HALF    = '{row: 4'd3, col: 4'd4, len: 4'd4};
    localparam word_pos_t POS_TO      = '{row: 4'd3, col: 4'd8, len: 4'd2};
    localparam word_pos_t POS_PAST    = '{row: 4'd4, col: 4'd1, len: 4'd4};
    localparam word_pos_t POS_ON_HOUR = '{row: 4'd9, col: 4'd5, len: 4'd6};

    // Hour words, entry 0 is TWELVE
    localparam word_pos_t HOUR_WORDS [12] = '{
        '{row: 4'd8, col: 4'd5, len: 4'd6}, '{row: 4'd5, col: 4'd0, len: 4'd3},
        '{row: 4'd6, col: 4'd4, len: 4'd3}, '{row: 4'd5, col: 4'd6, len: 4'd5},
        '{row: 4'd6, col: 4'd0, len: 4'd4}, '{row: 4'd6, col: 4'd7, len: 4'd4},
        '{row: 4'd5, col: 4'd3, len: 4'd3}, '{row: 4'd8, col: 4'd0, len: 4'd5},
        '{row: 4'd7, col: 4'd0, len: 4'd5}, '{row: 4'd4, col: 4'd7, len: 4'd4},
        '{row: 4'd9, col: 4'd0, len: 4'd3}, '{row: 4'd7, col: 4'd5, len: 4'd6}
    };

    // Fine-minute LEDs lit for 0..4 extra minutes (wired order 3, 2, 0, 1)
    localparam logic [3:0] FINE_MASK [5] = '{4'h0, 4'h8, 4'hC, 4'hD, 4'hF};

    // Mask of one word on a given row, zero when the word sits elsewhere
    function automatic logic [10:0] word_row_mask(word_pos_t w, logic [3:0] row);
        logic [11:0] ones;
        logic [11:0] shifted;
        begin
            ones    = (12'd1 << w.len) - 12'd1;
            shifted = ones << w.col;
            return (w.row == row) ? shifted[10:0] : 11'd0;
        end
    endfunction

endpackage

// ----- hdl/wcfb_front.sv -----
// Front end: accepts a time request and classifies it into a frame descriptor.
module wcfb_front
    import wcfb_pkg::*;
(
    input  logic        start,
    input  logic        queue_full,
    input  time_req_t   req,
    input  logic        show_it_is,
    output logic        push,
    output frame_desc_t desc
);

    logic        bad;
    logic [9:0]  prod;
    logic [3:0]  step_q;
    logic [5:0]  step_base;
    logic [5:0]  fine_full;
    logic        past;
    logic [4:0]  hour_adv;
    logic [4:0]  hour_fold;

    // Accept whenever the queue has room
    assign push = start && !queue_full;

    // Range check
    assign bad = (req.hour_of_day > MAX_HOUR) || (req.minute_of_hour > MAX_MINUTE);

    // Divide minute by five: multiply by 13/64, exact for 0..59
    assign prod      = 10'(req.minute_of_hour) * 10'd13;
    assign step_q    = prod[9:6];
    assign step_base = 6'(step_q) * MIN_STEP;
    assign fine_full = req.minute_of_hour - step_base;

    // Choose PAST or TO and fold the hour onto the dial
    assign past     = (req.minute_of_hour < MIN_STEP) || (req.minute_of_hour <= PAST_LIMIT);
    assign hour_adv = req.hour_of_day + 5'(!past);

    always_comb
    begin
        if (hour_adv >= (HOURS_ON_DIAL << 1))
            hour_fold = hour_adv - (HOURS_ON_DIAL << 1);
        else if (hour_adv >= HOURS_ON_DIAL)
            hour_fold = hour_adv - HOURS_ON_DIAL;
        else
            hour_fold = hour_adv;
    end

    // Build the descriptor
    always_comb
    begin
        desc          = '0;
        desc.bad      = bad;
        if (!bad)
        begin
            desc.it_is    = show_it_is;
            desc.hour_sel = hour_fold[3:0];
            desc.fine     = fine_full[2:0];
            if (req.minute_of_hour < MIN_STEP)
            begin
                desc.oclock = 1'b1;
            end
            else
            begin
                desc.past = past;
                desc.to   = !past;
                case (step_q) inside
                    4'd1, 4'd11: desc.five    = 1'b1;
                    4'd2, 4'd10: desc.ten     = 1'b1;
                    4'd3, 4'd9:  desc.quarter = 1'b1;
                    4'd4, 4'd8:  desc.twenty  = 1'b1;
                    4'd5, 4'd7:
                    begin
                        desc.twenty = 1'b1;
                        desc.five   = 1'b1;
                    end
                    default:     desc.half    = 1'b1;
                endcase
            end
        end
    end

endmodule

// ----- hdl/wcfb_queue.sv -----
// Small descriptor queue between the front end and the row emitter.
module wcfb_queue
    import wcfb_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output frame_desc_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_desc_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming descriptor
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ----- hdl/wcfb_back.sv -----
// Back end: walks the head descriptor row by row and registers each row result.
module wcfb_back
    import wcfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        desc_valid,
    input  frame_desc_t desc,
    input  logic        snake_wiring,
    output logic        pop,
    output logic        row_strobe,
    output row_result_t row
);

    logic [3:0]  row_cnt_reg, row_cnt_next;
    logic        strobe_reg, strobe_next;
    row_result_t row_reg, row_next;
    logic [10:0] leds;
    logic [10:0] leds_out;

    assign pop        = desc_valid && (row_cnt_reg == LAST_ROW);
    assign row_strobe = strobe_reg;
    assign row        = row_reg;

    // Gather the words that fall on the current row
    always_comb
    begin
        leds = '0;
        if (!desc.bad)
        begin
            if (desc.it_is)
                leds = leds | word_row_mask(POS_IT, row_cnt_reg)
                            | word_row_mask(POS_IS, row_cnt_reg);
            if (desc.oclock)  leds = leds | word_row_mask(POS_ON_HOUR, row_cnt_reg);
            if (desc.five)    leds = leds | word_row_mask(POS_FIVE, row_cnt_reg);
            if (desc.ten)     leds = leds | word_row_mask(POS_TEN, row_cnt_reg);
            if (desc.quarter) leds = leds | word_row_mask(POS_QTR, row_cnt_reg);
            if (desc.twenty)  leds = leds | word_row_mask(POS_TWENTY, row_cnt_reg);
            if (desc.half)    leds = leds | word_row_mask(POS_HALF, row_cnt_reg);
            if (desc.past)    leds = leds | word_row_mask(POS_PAST, row_cnt_reg);
            if (desc.to)      leds = leds | word_row_mask(POS_TO, row_cnt_reg);
            leds = leds | word_row_mask(HOUR_WORDS[desc.hour_sel], row_cnt_reg);
            if (row_cnt_reg == LAST_ROW)
                leds = leds | {7'd0, FINE_MASK[desc.fine]};
        end
    end

    // Reverse odd rows for snake wiring; the fine row is even and stays put
    always_comb
    begin
        leds_out = leds;
        if (snake_wiring && row_cnt_reg[0])
        begin
            for (int k = 0; k < GRID_COLS; k++)
                leds_out[k] = leds[GRID_COLS - 1 - k];
        end
    end

    // Advance the row counter and load the output register
    always_comb
    begin
        row_cnt_next       = row_cnt_reg;
        strobe_next        = desc_valid;
        row_next           = row_reg;
        if (desc_valid)
        begin
            row_next.row_index = row_cnt_reg;
            row_next.row_leds  = leds_out;
            row_next.last_row  = (row_cnt_reg == LAST_ROW);
            row_next.bad_time  = desc.bad;
            row_cnt_next       = (row_cnt_reg == LAST_ROW) ? 4'd0 : row_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Hold the row payload
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

endmodule

// ----- hdl/word_clock_frame_builder.sv -----
// Top level of the word clock frame builder: config registers, front end, queue, back end.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | req   (hour_of_day, minute_of_hour)
//  result    | row_strobe           | row   (row_index, row_leds, last_row, bad_time)
//  config    | cfg_we               | cfg_index, cfg_data
//
// Each request yields eleven rows, one per cycle, row 0 first; the row emitter
// is the bottleneck and so sets the sustained throughput of requests.
// With the queue empty, a taken request passes the queue entry register, then the row register.
// The descriptor queue (QUEUE_DEPTH entries) takes new requests while rows are
// still going out; busy is high only while it is full. The receiver cannot stall.
// Reset empties the queue and sets show_it_is and snake_wiring to 1.
module word_clock_frame_builder
    import wcfb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  time_req_t   req,
    output logic        row_strobe,
    output row_result_t row,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data
);

    logic        show_it_is_reg, show_it_is_next;
    logic        snake_wiring_reg, snake_wiring_next;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_not_empty;
    frame_desc_t front_desc;
    frame_desc_t head_desc;

    assign busy = queue_full;

    // Decode configuration writes
    always_comb
    begin
        show_it_is_next   = show_it_is_reg;
        snake_wiring_next = snake_wiring_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHOW_IT_IS:   show_it_is_next   = cfg_data[0];
                CFG_SNAKE_WIRING: snake_wiring_next = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_it_is_reg   <= 1'b1;
            snake_wiring_reg <= 1'b1;
        end
        else
        begin
            show_it_is_reg   <= show_it_is_next;
            snake_wiring_reg <= snake_wiring_next;
        end
    end

    // Classify requests
    wcfb_front u_front (
        .start      (start),
        .queue_full (queue_full),
        .req        (req),
        .show_it_is (show_it_is_reg),
        .push       (push),
        .desc       (front_desc)
    );

    // Buffer descriptors
    wcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_desc)
    );

    // Emit rows
    wcfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (queue_not_empty),
        .desc         (head_desc),
        .snake_wiring (snake_wiring_reg),
        .pop          (pop),
        .row_strobe   (row_strobe),
        .row          (row)
    );

endmodule
